[hw/rtl/qbd_pkg.sv]
// Shared types and constants for the quadtree bitmap decoder.
// Depends on nothing; used by qbd_step and quadtree_bitmap_decoder.
package qbd_pkg;

   // Default geometry
   localparam int TILE_LOG2_DEF        = 6;
   localparam int MAX_TILES_ACROSS_DEF = 256;
   localparam int MAX_TILES_DOWN_DEF   = 1024;

   // Bits per coded byte, one decode step each
   localparam int STEPS = 8;

   // Field widths
   localparam int BYTE_W     = 8;
   localparam int SQ_X_W     = 14;
   localparam int SQ_Y_W     = 16;
   localparam int SIZE_W     = 3;
   localparam int ACROSS_W   = 9;
   localparam int DOWN_W     = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILES_ACROSS = 1'b0,
      CSR_TILES_DOWN   = 1'b1
   } qbd_csr_type;

   // One fill record
   typedef struct packed {
      logic [SQ_X_W-1:0] square_x;
      logic [SQ_Y_W-1:0] square_y;
      logic [SIZE_W-1:0] size_log2;
      logic              white;
      logic              image_done;
   } qbd_rec_type;

endpackage

[hw/rtl/qbd_step.sv]
// One bit of quadtree decoding: flag, colour or leaf, with tile advance.
// Depends on qbd_pkg; chained eight deep in quadtree_bitmap_decoder.
module qbd_step #(
   parameter int  TILE_LOG2 = qbd_pkg::TILE_LOG2_DEF,
   parameter int  COL_W     = 8,
   parameter int  ROW_W     = 10,
   localparam int LVL_W     = $clog2(TILE_LOG2 + 1)
) (
   input  logic                        code_bit,
   input  logic [TILE_LOG2-1:0][1:0]   stack_in,
   input  logic [LVL_W-1:0]            level_in,
   input  logic                        colour_in,
   input  logic [COL_W-1:0]            col_in,
   input  logic [ROW_W-1:0]            row_in,
   input  logic                        finished_in,
   input  logic [COL_W-1:0]            across_last,
   input  logic [ROW_W-1:0]            down_last,
   output logic [TILE_LOG2-1:0][1:0]   stack_out,
   output logic [LVL_W-1:0]            level_out,
   output logic                        colour_out,
   output logic [COL_W-1:0]            col_out,
   output logic [ROW_W-1:0]            row_out,
   output logic                        finished_out,
   output logic                        rec_valid,
   output qbd_pkg::qbd_rec_type        rec_out
);
   import qbd_pkg::*;

   localparam int XW = COL_W + TILE_LOG2;
   localparam int YW = ROW_W + TILE_LOG2;

   logic [TILE_LOG2-1:0]      off_x;
   logic [TILE_LOG2-1:0]      off_y;
   logic [LVL_W-1:0]          size_raw;
   logic [LVL_W+SIZE_W-1:0]   size_ext;
   logic [XW+SQ_X_W-1:0]      x_ext;
   logic [YW+SQ_Y_W-1:0]      y_ext;
   logic                      is_flag;
   logic                      found;
   logic [LVL_W-1:0]          pos;

   // Offset inside the tile from the quadrants taken so far
   always_comb begin
      off_x = '0;
      off_y = '0;
      for (int i = 0; i < TILE_LOG2; i++) begin
         if (level_in > LVL_W'(i)) begin
            off_x[TILE_LOG2-1-i] = stack_in[i][0];
            off_y[TILE_LOG2-1-i] = stack_in[i][1];
         end
      end
   end

   assign size_raw = LVL_W'(TILE_LOG2) - level_in;
   assign size_ext = (LVL_W + SIZE_W)'(size_raw);
   assign x_ext    = (XW + SQ_X_W)'({col_in, off_x});
   assign y_ext    = (YW + SQ_Y_W)'({row_in, off_y});
   assign is_flag  = !colour_in && (level_in != LVL_W'(TILE_LOG2));

   // Deepest level whose quadrant is not yet the last one
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = 0; i < TILE_LOG2; i++) begin
         if ((level_in > LVL_W'(i)) && (stack_in[i] != 2'd3)) begin
            found = 1'b1;
            pos   = LVL_W'(i);
         end
      end
   end

   // Apply the bit to the decode position
   always_comb begin
      stack_out            = stack_in;
      level_out            = level_in;
      colour_out           = colour_in;
      col_out              = col_in;
      row_out              = row_in;
      finished_out         = finished_in;
      rec_valid            = 1'b0;
      rec_out.square_x     = x_ext[SQ_X_W-1:0];
      rec_out.square_y     = y_ext[SQ_Y_W-1:0];
      rec_out.size_log2    = size_ext[SIZE_W-1:0];
      rec_out.white        = code_bit;
      rec_out.image_done   = 1'b0;
      if (!finished_in) begin
         if (is_flag) begin
            if (code_bit) begin
               colour_out = 1'b1;
            end else begin
               // split: descend into top-left quadrant
               for (int i = 0; i < TILE_LOG2; i++) begin
                  if (level_in == LVL_W'(i)) begin
                     stack_out[i] = 2'd0;
                  end
               end
               level_out = level_in + LVL_W'(1);
            end
         end else begin
            // leaf: emit fill and move to the next square
            rec_valid  = 1'b1;
            colour_out = 1'b0;
            if (found) begin
               level_out = pos + LVL_W'(1);
               for (int i = 0; i < TILE_LOG2; i++) begin
                  if (pos == LVL_W'(i)) begin
                     stack_out[i] = stack_in[i] + 2'd1;
                  end
               end
            end else begin
               level_out = '0;
               if (col_in >= across_last) begin
                  col_out = '0;
                  if (row_in >= down_last) begin
                     finished_out       = 1'b1;
                     rec_out.image_done = 1'b1;
                  end else begin
                     row_out = row_in + ROW_W'(1);
                  end
               end else begin
                  col_out = col_in + COL_W'(1);
               end
            end
         end
      end
   end

endmodule

[hw/rtl/quadtree_bitmap_decoder.sv]
// Top level of the quadtree bitmap decoder: input register, eight-step
// decode chain (qbd_step), fill record bank and configuration registers.
// Depends on qbd_pkg and qbd_step.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_stream_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_square_x/_y, rsp_size_log2,
//                                            rsp_white, rsp_image_done, rsp_last
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A byte waits in the input register, then all eight bits are decoded
// into the record bank; its first record is offered the next cycle. One
// byte per cycle is sustained while each byte gives at most one record
// and rsp_ready is high; a byte giving more records holds the result port
// until all are taken, since the bank drains one record per cycle. Reset
// is synchronous and needs no clearing pass. A stalled result port holds
// the bank and then the input register; csr_ready is always high.
module quadtree_bitmap_decoder #(
   parameter int TILE_LOG2        = qbd_pkg::TILE_LOG2_DEF,
   parameter int MAX_TILES_ACROSS = qbd_pkg::MAX_TILES_ACROSS_DEF,
   parameter int MAX_TILES_DOWN   = qbd_pkg::MAX_TILES_DOWN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [qbd_pkg::BYTE_W-1:0]      req_stream_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [qbd_pkg::SQ_X_W-1:0]      rsp_square_x,
   output logic [qbd_pkg::SQ_Y_W-1:0]      rsp_square_y,
   output logic [qbd_pkg::SIZE_W-1:0]      rsp_size_log2,
   output logic                            rsp_white,
   output logic                            rsp_image_done,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qbd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import qbd_pkg::*;

   localparam int LVL_W = $clog2(TILE_LOG2 + 1);
   localparam int COL_W = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
   localparam int ROW_W = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1;
   localparam int AC_CW = $clog2(MAX_TILES_ACROSS + 1);
   localparam int DN_CW = $clog2(MAX_TILES_DOWN + 1);
   localparam int AW    = (AC_CW > ACROSS_W) ? AC_CW : ACROSS_W;
   localparam int DW    = (DN_CW > DOWN_W) ? DN_CW : DOWN_W;
   localparam int SEL_W = $clog2(STEPS);

   // Configuration registers
   logic [ACROSS_W-1:0]  tiles_across_ff;
   logic [DOWN_W-1:0]    tiles_down_ff;

   // Decode position
   logic [TILE_LOG2-1:0][1:0] stack_ff;
   logic [LVL_W-1:0]          level_ff;
   logic                      colour_ff;
   logic [COL_W-1:0]          col_ff;
   logic [ROW_W-1:0]          row_ff;
   logic                      finished_ff;

   // Input register
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [BYTE_W-1:0]    s1_byte_ff;

   // Record bank
   qbd_rec_type          bank_ff [STEPS];
   logic [STEPS-1:0]     pend_ff;
   logic [STEPS-1:0]     pend_in;
   logic [STEPS-1:0]     pend_rest;

   // Decode chain
   logic [TILE_LOG2-1:0][1:0] stack_c [STEPS+1];
   logic [LVL_W-1:0]          level_c [STEPS+1];
   logic [STEPS:0]            colour_c;
   logic [COL_W-1:0]          col_c [STEPS+1];
   logic [ROW_W-1:0]          row_c [STEPS+1];
   logic [STEPS:0]            finished_c;
   logic [STEPS-1:0]          emit_c;
   qbd_rec_type               rec_c [STEPS];

   logic [AW-1:0]        across_ext;
   logic [AW-1:0]        across_lim;
   logic [AW-1:0]        across_m1;
   logic [DW-1:0]        down_ext;
   logic [DW-1:0]        down_lim;
   logic [DW-1:0]        down_m1;
   logic [COL_W-1:0]     across_last;
   logic [ROW_W-1:0]     down_last;
   logic                 bank_free;
   logic                 move;
   logic                 take;
   logic [SEL_W-1:0]     sel;

   // Clamp tile counts to 1..max, then form last index
   assign across_ext  = AW'(tiles_across_ff);
   assign down_ext    = DW'(tiles_down_ff);
   assign across_lim  = (across_ext == '0) ? AW'(1) :
                        (across_ext > AW'(MAX_TILES_ACROSS)) ? AW'(MAX_TILES_ACROSS) :
                        across_ext;
   assign down_lim    = (down_ext == '0) ? DW'(1) :
                        (down_ext > DW'(MAX_TILES_DOWN)) ? DW'(MAX_TILES_DOWN) : down_ext;
   assign across_m1   = across_lim - AW'(1);
   assign down_m1     = down_lim - DW'(1);
   assign across_last = across_m1[COL_W-1:0];
   assign down_last   = down_m1[ROW_W-1:0];

   // Configuration write port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tiles_across_ff <= ACROSS_W'(1);
         tiles_down_ff   <= DOWN_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TILES_ACROSS: tiles_across_ff <= csr_wdata[ACROSS_W-1:0];
            CSR_TILES_DOWN:   tiles_down_ff   <= csr_wdata[DOWN_W-1:0];
            default:          ;
         endcase
      end
   end

   // Eight bit steps, most significant bit first
   assign stack_c[0]    = stack_ff;
   assign level_c[0]    = level_ff;
   assign colour_c[0]   = colour_ff;
   assign col_c[0]      = col_ff;
   assign row_c[0]      = row_ff;
   assign finished_c[0] = finished_ff;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      qbd_step #(
         .TILE_LOG2 (TILE_LOG2),
         .COL_W     (COL_W),
         .ROW_W     (ROW_W)
      ) u_step (
         .code_bit     (s1_byte_ff[STEPS-1-k]),
         .stack_in     (stack_c[k]),
         .level_in     (level_c[k]),
         .colour_in    (colour_c[k]),
         .col_in       (col_c[k]),
         .row_in       (row_c[k]),
         .finished_in  (finished_c[k]),
         .across_last  (across_last),
         .down_last    (down_last),
         .stack_out    (stack_c[k+1]),
         .level_out    (level_c[k+1]),
         .colour_out   (colour_c[k+1]),
         .col_out      (col_c[k+1]),
         .row_out      (row_c[k+1]),
         .finished_out (finished_c[k+1]),
         .rec_valid    (emit_c[k]),
         .rec_out      (rec_c[k])
      );
   end

   // Handshake: bank takes a new byte when empty or on its final record
   assign pend_rest   = pend_ff & (pend_ff - STEPS'(1));
   assign rsp_valid   = (pend_ff != '0);
   assign take        = rsp_valid && rsp_ready;
   assign bank_free   = (pend_ff == '0) || (take && (pend_rest == '0));
   assign move        = s1_valid_ff && bank_free;
   assign req_ready   = !s1_valid_ff || move;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !move);

   always_comb begin
      if (move) begin
         pend_in = emit_c;
      end else if (take) begin
         pend_in = pend_rest;
      end else begin
         pend_in = pend_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pend_ff     <= '0;
         stack_ff    <= '0;
         level_ff    <= '0;
         colour_ff   <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         finished_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pend_ff     <= pend_in;
         if (move) begin
            stack_ff    <= stack_c[STEPS];
            level_ff    <= level_c[STEPS];
            colour_ff   <= colour_c[STEPS];
            col_ff      <= col_c[STEPS];
            row_ff      <= row_c[STEPS];
            finished_ff <= finished_c[STEPS];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_stream_byte;
      end
      if (move) begin
         for (int k = 0; k < STEPS; k++) begin
            bank_ff[k] <= rec_c[k];
         end
      end
   end

   // Offer the oldest pending record
   always_comb begin
      sel = '0;
      for (int k = STEPS - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            sel = SEL_W'(k);
         end
      end
   end

   assign rsp_square_x   = bank_ff[sel].square_x;
   assign rsp_square_y   = bank_ff[sel].square_y;
   assign rsp_size_log2  = bank_ff[sel].size_log2;
   assign rsp_white      = bank_ff[sel].white;
   assign rsp_image_done = bank_ff[sel].image_done;
   assign rsp_last       = (pend_rest == '0);

   // Once finished, the image stays finished until reset
   a_finished_sticky : assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag dropped");

   // Depth never exceeds the tile size
   a_level_range : assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(TILE_LOG2))
      else $error("tree level out of range");

   // Single pixels carry no flag, so no colour is pending at full depth
   a_leaf_no_colour : assert property (@(posedge clock) disable iff (reset)
      (level_ff == LVL_W'(TILE_LOG2)) |-> !colour_ff)
      else $error("colour pending at pixel level");

   // A taken record that is not the last of its byte is followed by another
   a_burst_continues : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("records of one byte interrupted");

endmodule
